// ===== hdl/sgef_pkg.sv =====
// ----------------------------------------------------------------------------
// sgef_pkg
// Shared types, codes and constants for the sensor gain, exposure and
// frame-length request translator.
// ----------------------------------------------------------------------------
package sgef_pkg;

	// datapath widths
	localparam int unsigned MUL_W     = 32;
	localparam int unsigned PROD_W    = 2 * MUL_W;
	localparam int unsigned DVS_W     = 48;
	localparam int unsigned MUL_STEPS = MUL_W;
	localparam int unsigned DIV_STEPS = PROD_W;

	// request operations
	typedef logic [1:0] op_t;
	localparam op_t OP_GAIN     = 2'd0;
	localparam op_t OP_EXPOSURE = 2'd1;
	localparam op_t OP_FRAMERATE = 2'd2;
	localparam op_t OP_NONE     = 2'd3;

	// sensor register targets
	typedef logic [1:0] tgt_t;
	localparam tgt_t TGT_MODE = 2'd0;
	localparam tgt_t TGT_GAIN = 2'd1;
	localparam tgt_t TGT_CIT  = 2'd2;
	localparam tgt_t TGT_FLL  = 2'd3;

	// configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_GAIN_UNIT   = 3'd0;
	localparam cfg_idx_t CFG_PCLK        = 3'd1;
	localparam cfg_idx_t CFG_LINE_PIX    = 3'd2;
	localparam cfg_idx_t CFG_EXP_SCALE   = 3'd3;
	localparam cfg_idx_t CFG_FR_SCALE    = 3'd4;

	// sensor limits
	localparam logic [15:0] FLL_RESET    = 16'd2445;
	localparam logic [15:0] FLL_LOW      = 16'd1216;
	localparam logic [15:0] FLL_HIGH     = 16'hFFFF;
	localparam logic [15:0] FLL_OVERHEAD = 16'd5;
	localparam logic [15:0] CIT_LOW      = 16'd2;
	localparam logic [15:0] CIT_MARGIN   = 16'd1;
	localparam logic [7:0]  MODE_SPLIT   = 8'h36;
	localparam logic [3:0]  COARSE_TOP   = 4'd15;
	localparam logic [3:0]  COARSE_FINE  = 4'd4;
	localparam int unsigned FINE_SHIFT   = 5;

	// one register write
	typedef struct packed {
		tgt_t        target_register;
		logic [15:0] register_value;
		logic        high_gain_mode;
		logic        error;
		logic        last;
	} res_t;

endpackage

// ===== hdl/sgef_if.sv =====
// ----------------------------------------------------------------------------
// sgef_if
// Valid/ready channels: requests, register writes out, configuration writes.
// ----------------------------------------------------------------------------
interface sgef_req_if;
	import sgef_pkg::*;
	logic        valid;
	logic        ready;
	op_t         operation;
	logic [31:0] request_value;
	modport source (output valid, operation, request_value, input ready);
	modport sink (input valid, operation, request_value, output ready);
endinterface

interface sgef_rsp_if;
	import sgef_pkg::*;
	logic        valid;
	logic        ready;
	tgt_t        target_register;
	logic [15:0] register_value;
	logic        high_gain_mode;
	logic        error;
	logic        last;
	modport source (output valid, target_register, register_value, high_gain_mode,
		error, last, input ready);
	modport sink (input valid, target_register, register_value, high_gain_mode,
		error, last, output ready);
endinterface

interface sgef_cfg_if;
	import sgef_pkg::*;
	logic        valid;
	logic        ready;
	cfg_idx_t    reg_index;
	logic [31:0] wr_data;
	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hdl/sgef_mul.sv =====
// ----------------------------------------------------------------------------
// sgef_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sgef_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sgef_pkg::MUL_W-1:0]     a,
	input  logic [sgef_pkg::MUL_W-1:0]     b,
	output logic                           done,
	output logic [sgef_pkg::PROD_W-1:0]    product
);
	import sgef_pkg::*;

	localparam int unsigned CNT_W = $clog2(MUL_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

	logic [MUL_W-1:0]  a_q;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_W:0]    sum;

	// partial sum of the upper half with the current multiplier bit
	always_comb begin
		sum = {1'b0, prod_q[PROD_W-1:MUL_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product shift register: low half holds the multiplier bits still to go
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[MUL_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

// ===== hdl/sgef_div.sv =====
// ----------------------------------------------------------------------------
// sgef_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgef_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sgef_pkg::PROD_W-1:0]    dividend,
	input  logic [sgef_pkg::DVS_W-1:0]     divisor,
	output logic                           done,
	output logic [sgef_pkg::PROD_W-1:0]    quotient
);
	import sgef_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[PROD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/sensor_gain_exposure_framing.sv =====
// ----------------------------------------------------------------------------
// sensor_gain_exposure_framing
// Turns gain, exposure and frame-rate requests into sensor register writes.
// ----------------------------------------------------------------------------
// Exposure and frame rate: the serial multipliers, then the divider, then the
// output register.
// Gain: the coarse step search, then the divider when the fine step needs it;
// a zero divisor goes straight to its error result.
// One request at a time; a new one is taken while the last result waits.
// Reset: frame length 2445 lines, high gain mode, registers 1,0,0,1,1.
// ----------------------------------------------------------------------------
module sensor_gain_exposure_framing (
	input  logic      clk,
	input  logic      arst_n,
	sgef_cfg_if.sink  cfg,
	sgef_req_if.sink  req,
	sgef_rsp_if.source rsp
);
	import sgef_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_LOG, ST_MUL, ST_DIV, ST_FIN, ST_EMIT} state_t;

	// configuration registers
	logic [15:0] gain_unit_q;
	logic [31:0] pclk_q;
	logic [15:0] line_pix_q;
	logic [31:0] exp_scale_q;
	logic [31:0] fr_scale_q;

	state_t      state_q;
	op_t         op_q;
	logic [31:0] v_q;
	logic [31:0] sh_q;
	logic [3:0]  coarse_q;
	logic [4:0]  fine_q;
	res_t        res0_q;
	res_t        res1_q;
	logic        has1_q;
	res_t        out_q;
	logic        out_valid_q;
	logic [15:0] cur_fll_q;
	logic        mode_q;

	logic              req_fire;
	logic              rsp_fire;
	logic              emit_load;
	logic              req_err;
	logic [32:0]       sh_next;
	logic              log_step;
	logic              gain_div;
	logic [31:0]       gain_diff;
	logic              mul_start;
	logic [MUL_W-1:0]  mul0_b;
	logic [MUL_W-1:0]  mul1_b;
	logic              mul0_done;
	logic              mul1_done;
	logic [PROD_W-1:0] prod0;
	logic [PROD_W-1:0] prod1;
	logic              div_start;
	logic [PROD_W-1:0] div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	logic              div_done;
	logic [PROD_W-1:0] quo;
	logic [4:0]        fine_m;
	logic [7:0]        code;
	logic              mode_new;
	logic [15:0]       cit_top;
	logic [15:0]       cit;
	logic [PROD_W-1:0] fll_wide;
	logic [15:0]       fll;

	function automatic res_t make_res(tgt_t t, logic [15:0] val, logic hg, logic err,
		logic lst);
		res_t r;
		r.target_register = t;
		r.register_value  = val;
		r.high_gain_mode  = hg;
		r.error           = err;
		r.last            = lst;
		return r;
	endfunction

	function automatic tgt_t op_target(op_t op);
		tgt_t t;
		case (op)
			OP_GAIN:      t = TGT_GAIN;
			OP_EXPOSURE:  t = TGT_CIT;
			OP_FRAMERATE: t = TGT_FLL;
			default:      t = TGT_GAIN;
		endcase
		return t;
	endfunction

	// configuration writes, always accepted
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_unit_q <= 16'd1;
			pclk_q      <= '0;
			line_pix_q  <= '0;
			exp_scale_q <= 32'd1;
			fr_scale_q  <= 32'd1;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_GAIN_UNIT: gain_unit_q <= cfg.wr_data[15:0];
				CFG_PCLK:      pclk_q      <= cfg.wr_data;
				CFG_LINE_PIX:  line_pix_q  <= cfg.wr_data[15:0];
				CFG_EXP_SCALE: exp_scale_q <= cfg.wr_data;
				CFG_FR_SCALE:  fr_scale_q  <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// handshakes and zero-divisor check
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		req_fire  = req.valid && req.ready;
		rsp_fire  = rsp.valid && rsp.ready;
		emit_load = (state_q == ST_EMIT) && (!out_valid_q || rsp_fire);
		case (req.operation)
			OP_GAIN:      req_err = (gain_unit_q == '0) || (req.request_value == '0);
			OP_EXPOSURE:  req_err = (exp_scale_q == '0) || (line_pix_q == '0);
			OP_FRAMERATE: req_err = (line_pix_q == '0) || (req.request_value == '0);
			default:      req_err = 1'b0;
		endcase
	end

	// coarse gain step: largest c, up to 15, with gain_unit << c not above the request
	always_comb begin
		sh_next   = {sh_q, 1'b0};
		log_step  = (coarse_q != COARSE_TOP) && (sh_next <= {1'b0, v_q});
		gain_div  = (coarse_q < COARSE_FINE) && (v_q > sh_q);
		gain_diff = v_q - sh_q;
	end

	// multiplier and divider operands
	always_comb begin
		mul_start = req_fire && !req_err &&
			(req.operation == OP_EXPOSURE || req.operation == OP_FRAMERATE);
		mul0_b = (req.operation == OP_EXPOSURE) ? req.request_value : fr_scale_q;
		mul1_b = (req.operation == OP_EXPOSURE) ? exp_scale_q : req.request_value;

		div_start = ((state_q == ST_LOG) && !log_step && gain_div) ||
			((state_q == ST_MUL) && mul0_done);
		if (state_q == ST_LOG) begin
			div_dividend = {{(PROD_W - 32 - FINE_SHIFT){1'b0}}, gain_diff,
				{FINE_SHIFT{1'b0}}};
			div_divisor  = {{(DVS_W - 32){1'b0}}, v_q};
		end else begin
			div_dividend = prod0;
			div_divisor  = prod1[DVS_W-1:0];
		end
	end

	sgef_mul u_mul0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (pclk_q),
		.b       (mul0_b),
		.done    (mul0_done),
		.product (prod0)
	);

	sgef_mul u_mul1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       ({{(MUL_W - 16){1'b0}}, line_pix_q}),
		.b       (mul1_b),
		.done    (mul1_done),
		.product (prod1)
	);

	sgef_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// final values: gain code, clamped lines, saturated frame length
	always_comb begin
		fine_m   = {fine_q[4:1], fine_q[0] & ~coarse_q[0]};
		code     = {coarse_q, fine_m[3:0]};
		mode_new = (code < MODE_SPLIT);

		cit_top = (cur_fll_q > CIT_MARGIN) ? cur_fll_q - CIT_MARGIN : '0;
		if (quo < PROD_W'(CIT_LOW))
			cit = CIT_LOW;
		else if (quo > PROD_W'(cit_top))
			cit = cit_top;
		else
			cit = quo[15:0];

		fll_wide = quo - PROD_W'(FLL_OVERHEAD);
		if (quo < PROD_W'(FLL_LOW) + PROD_W'(FLL_OVERHEAD))
			fll = FLL_LOW;
		else if (fll_wide > PROD_W'(FLL_HIGH))
			fll = FLL_HIGH;
		else
			fll = fll_wide[15:0];
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_GAIN;
			v_q       <= '0;
			sh_q      <= '0;
			coarse_q  <= '0;
			fine_q    <= '0;
			res0_q    <= '0;
			res1_q    <= '0;
			has1_q    <= 1'b0;
			cur_fll_q <= FLL_RESET;
			mode_q    <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						op_q <= req.operation;
						v_q  <= req.request_value;
						if (req.operation == OP_NONE) begin
							state_q <= ST_IDLE;
						end else if (req_err) begin
							res0_q  <= make_res(op_target(req.operation), '0, 1'b0,
								1'b1, 1'b1);
							has1_q  <= 1'b0;
							state_q <= ST_EMIT;
						end else if (req.operation == OP_GAIN) begin
							sh_q     <= {16'd0, gain_unit_q};
							coarse_q <= '0;
							fine_q   <= '0;
							state_q  <= ST_LOG;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_LOG: begin
					if (log_step) begin
						sh_q     <= sh_next[31:0];
						coarse_q <= coarse_q + 4'd1;
					end else if (gain_div) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MUL: begin
					if (mul0_done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (op_q == OP_GAIN)
							fine_q <= quo[4:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					has1_q  <= (op_q == OP_GAIN) && (mode_new != mode_q);
					state_q <= ST_EMIT;
					case (op_q)
						OP_GAIN: begin
							if (mode_new != mode_q) begin
								res0_q <= make_res(TGT_MODE, '0, mode_new, 1'b0, 1'b0);
								res1_q <= make_res(TGT_GAIN, {8'd0, code}, 1'b0, 1'b0, 1'b1);
								mode_q <= mode_new;
							end else begin
								res0_q <= make_res(TGT_GAIN, {8'd0, code}, 1'b0, 1'b0, 1'b1);
							end
						end
						OP_EXPOSURE: res0_q <= make_res(TGT_CIT, cit, 1'b0, 1'b0, 1'b1);
						OP_FRAMERATE: begin
							res0_q    <= make_res(TGT_FLL, fll, 1'b0, 1'b0, 1'b1);
							cur_fll_q <= fll;
						end
						default: ;
					endcase
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (has1_q) begin
							res0_q <= res1_q;
							has1_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_q       <= res0_q;
			out_valid_q <= 1'b1;
		end else if (rsp_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// result channel
	assign rsp.valid           = out_valid_q;
	assign rsp.target_register = out_q.target_register;
	assign rsp.register_value  = out_q.register_value;
	assign rsp.high_gain_mode  = out_q.high_gain_mode;
	assign rsp.error           = out_q.error;
	assign rsp.last            = out_q.last;

	// checks
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul0_done == mul1_done)
		else $error("serial multipliers out of step");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error |-> rsp.last && rsp.register_value == '0 &&
		rsp.target_register != TGT_MODE)
		else $error("malformed error result");

	a_mode_first: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.target_register == TGT_MODE |-> !rsp.last && !rsp.error)
		else $error("mode write not followed by gain write");

	a_fll_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_fll_q >= FLL_LOW)
		else $error("frame length below minimum");

endmodule
